>>> rtl/stable_sorted_priority_queue_top_macros.svh
// Assertion macros for the sorted priority queue.
// Included by modules that check their own logic; needs nothing else.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define SSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sspq_pkg.sv
// Shared types and constants of the sorted priority queue.
// Used by the cell and the top level; depends on nothing.
package sspq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

>>> rtl/sspq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on sspq_pkg.
module sspq_cell
    import sspq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  logic       occupied,
    input  logic       left_keep,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output logic       keep,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Stay put on a push when this entry ranks at or ahead of the new one
    assign keep = occupied && (entry_reg.prio <= new_entry.prio);

    // Pick next content: hold, take the new entry, shift right or shift left
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue: a row of cells plus result register.
// Depends on sspq_pkg, sspq_cell and stable_sorted_priority_queue_top_macros.svh.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------------
//  command  | start & !busy      | command, data_value, priority_req
//  result   | done (one cycle)   | out_value, out_priority, status, occupancy
//
// A transaction's result shows with done on the cycle after the accepting edge,
// and busy stays low, so a new transaction may follow every cycle.
// That rate is set by the cell row, which compares all slots against the new
// priority in parallel and shifts in one step.
// Reset clears the entry count and the result strobe; the queue starts empty.
// The receiver cannot stall; done marks each result for a single cycle.
`include "stable_sorted_priority_queue_top_macros.svh"

module stable_sorted_priority_queue_top
    import sspq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic signed [31:0] data_value,
    input  logic signed [15:0] priority_req,
    output logic               done,
    output logic signed [31:0] out_value,
    output logic signed [15:0] out_priority,
    output logic [1:0]         status,
    output logic [4:0]         occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic [31:0]   value_reg;
    logic [15:0]   prio_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    entry_t        new_entry;
    entry_t        head;
    cell_ctrl_t    ctrl;
    logic          full;
    logic          empty;
    logic          accept;
    logic [CW+4:0] count_wide;

    entry_t               cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  cell_keep;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign new_entry = '{value: data_value, prio: priority_req};
    assign head      = cell_entry[0];

    // Drive the cell row only for transactions that change the queue
    assign ctrl.push = accept && (command == CMD_PUSH) && !full;
    assign ctrl.pop  = accept && (command == CMD_POP) && !empty;

    // Build the cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_keep;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = new_entry;
        end
        else
        begin : g_mid
            assign left_keep  = cell_keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = new_entry;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        sspq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .occupied    (count_reg > CW'(i)),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .keep        (cell_keep[i]),
            .entry       (cell_entry[i])
        );
    end

    // Advance the entry count and pick the status
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_PUSHED;
        if (command == CMD_PUSH)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_POPPED;
                count_next  = count_reg - CW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            if (ctrl.pop)
            begin
                value_reg <= head.value;
                prio_reg  <= head.prio;
            end
            else
            begin
                value_reg <= '0;
                prio_reg  <= '0;
            end
        end
    end

    assign count_wide   = {5'b0, count_reg};
    assign done         = done_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign status       = status_reg;
    assign occupancy    = count_wide[4:0];

    `SSPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY),
        "entry count above capacity")
    `SSPQ_ASSERT_NEXT(a_push_ok, clk, rst_n, ctrl.push,
        done && status == ST_PUSHED && count_reg == $past(count_reg) + CW'(1),
        "push did not add an entry")
    `SSPQ_ASSERT_NEXT(a_pop_head, clk, rst_n, ctrl.pop,
        out_priority == $past(head.prio) && out_value == $past(head.value),
        "pop did not return the head entry")
    `SSPQ_ASSERT_NEXT(a_empty_pop, clk, rst_n, accept && command == CMD_POP && empty,
        status == ST_EMPTY && out_value == 32'sd0 && count_reg == '0,
        "pop on empty queue changed state")
    `SSPQ_ASSERT_NOW(a_head_order, clk, rst_n, CAPACITY > 1 && count_reg > CW'(1),
        cell_entry[0].prio <= cell_entry[1].prio, "head entries out of order")

endmodule
